/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Every assertion samples on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The expression must never be true at a sampled edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
   `ASSERT_HOLDS(lbl, !(expr), msg)

`endif

/* sv/hsv2rgb_pkg.sv */
`default_nettype none

package hsv2rgb_pkg;

   // 1.0 in Q1.15.
   localparam logic [15:0] ONE_Q15 = 16'h8000;
   // 1.0 in Q0.16, one bit wider than the fraction itself.
   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam logic [2:0]  HUE_SCALE = 3'd6;
   localparam logic [4:0]  CHAN5_SCALE = 5'd31;
   localparam logic [5:0]  CHAN6_SCALE = 6'd63;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   // Raw fields of one input beat.
   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] saturation;
      logic [15:0] brightness;
   } pixel_in_type;

   // After the hue scaling: clamped saturation and value, sector and fraction.
   typedef struct packed {
      sector_type  sector;
      logic [15:0] frac;
      logic [15:0] sat;
      logic [15:0] val;
   } hue_split_type;

   // The three "one minus" factors that scale the value.
   typedef struct packed {
      sector_type  sector;
      logic [15:0] val;
      logic [15:0] one_minus_s;
      logic [15:0] one_minus_sf;
      logic [15:0] one_minus_sg;
   } factor_type;

   // Channel candidates, all Q1.15 in 0..1.0.
   typedef struct packed {
      sector_type  sector;
      logic [15:0] val;
      logic [15:0] p;
      logic [15:0] q;
      logic [15:0] t;
   } pqt_type;

   function automatic logic [4:0] chan5(input logic [15:0] x);
      logic [20:0] prod;
      prod = 21'(x) * 21'(CHAN5_SCALE);
      return prod[19:15];
   endfunction

   function automatic logic [5:0] chan6(input logic [15:0] x);
      logic [21:0] prod;
      prod = 22'(x) * 22'(CHAN6_SCALE);
      return prod[20:15];
   endfunction

endpackage

`default_nettype wire

/* sv/hsv_to_rgb565.sv */
`default_nettype none

// HSV to RGB565 converter for a pixel stream. Each request beat carries a hue
// (an unsigned fraction of a full turn), a saturation and a brightness (both
// Q1.15, values above 1.0 are clamped to 1.0); each response beat carries one
// packed 5/6/5 color word, red in the top bits. The datapath is four register
// stages: hue scaling and clamping, the saturation products, the three value
// multiplies that give p, q and t, and the channel select and pack into the
// output register. An accepted beat passes through these four registers in
// turn before it shows up on rsp_valid and can be taken, and one beat is
// accepted in every cycle as long as the response side keeps taking beats.
// Every stage has its own valid bit and advances whenever it is empty or the
// stage after it moves, so a stall on the response side backs up through the
// stages without dropping or repeating a beat, and bubbles are squeezed out
// while the output is stalled.
module hsv_to_rgb565 (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [15:0]  req_hue,
   input  wire  [15:0]  req_saturation,
   input  wire  [15:0]  req_brightness,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [15:0]  rsp_rgb565
);
   import hsv2rgb_pkg::*;

   pixel_in_type pixel;
   factor_type   factors;
   pqt_type      terms;
   logic         fact_valid;
   logic         fact_ready;
   logic         pqt_valid;
   logic         pqt_ready;

   // Bundle the request fields for the first stage.
   assign pixel.hue        = req_hue;
   assign pixel.saturation = req_saturation;
   assign pixel.brightness = req_brightness;

   // Stages one and two: sector, fraction and the one-minus factors.
   hsv2rgb_frac u_frac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (pixel),
      .out_valid (fact_valid),
      .out_ready (fact_ready),
      .out_data  (factors)
   );

   // Stage three: value times each factor.
   hsv2rgb_pqt u_pqt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fact_valid),
      .in_ready  (fact_ready),
      .in_data   (factors),
      .out_valid (pqt_valid),
      .out_ready (pqt_ready),
      .out_data  (terms)
   );

   // Stage four: the output register that holds the beat until it is taken.
   hsv2rgb_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pqt_valid),
      .in_ready  (pqt_ready),
      .in_data   (terms),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_rgb565)
   );

endmodule

`default_nettype wire

/* sv/hsv2rgb_frac.sv */
`default_nettype none

// Two stages: clamp and split the hue into sector and fraction, then form
// the saturation products and the one-minus factors.
module hsv2rgb_frac (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  hsv2rgb_pkg::pixel_in_type    in_data,
   output logic                         out_valid,
   input  wire                          out_ready,
   output hsv2rgb_pkg::factor_type      out_data
);
   import hsv2rgb_pkg::*;

   logic          split_valid_ff;
   hue_split_type split_ff;
   hue_split_type split_in;
   logic          split_ready;
   logic [18:0]   hue6;

   logic          fact_valid_ff;
   factor_type    fact_ff;
   factor_type    fact_in;
   logic          fact_ready;
   logic [31:0]   prod_sf;
   logic [32:0]   prod_sg;
   logic [16:0]   frac_comp;

   // Stage one.
   always_comb begin
      hue6 = 19'(in_data.hue) * 19'(HUE_SCALE);
      split_in.sector = sector_type'(hue6[18:16]);
      split_in.frac   = hue6[15:0];
      split_in.sat    = (in_data.saturation > ONE_Q15) ? ONE_Q15 : in_data.saturation;
      split_in.val    = (in_data.brightness > ONE_Q15) ? ONE_Q15 : in_data.brightness;
   end

   assign split_ready = !split_valid_ff || fact_ready;
   assign in_ready    = split_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_valid_ff <= 1'b0;
      end else if (split_ready) begin
         split_valid_ff <= in_valid;
      end
      if (split_ready && in_valid) begin
         split_ff <= split_in;
      end
   end

   // Stage two. Neither product exceeds 1.0 after the shift.
   always_comb begin
      frac_comp = ONE_Q16 - {1'b0, split_ff.frac};
      prod_sf   = 32'(split_ff.sat) * 32'(split_ff.frac);
      prod_sg   = 33'(split_ff.sat) * 33'(frac_comp);
      fact_in.sector       = split_ff.sector;
      fact_in.val          = split_ff.val;
      fact_in.one_minus_s  = ONE_Q15 - split_ff.sat;
      fact_in.one_minus_sf = ONE_Q15 - prod_sf[31:16];
      fact_in.one_minus_sg = ONE_Q15 - prod_sg[31:16];
   end

   assign fact_ready = !fact_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fact_valid_ff <= 1'b0;
      end else if (fact_ready) begin
         fact_valid_ff <= split_valid_ff;
      end
      if (fact_ready && split_valid_ff) begin
         fact_ff <= fact_in;
      end
   end

   assign out_valid = fact_valid_ff;
   assign out_data  = fact_ff;

`include "assert_macros.svh"

   `ASSERT_HOLDS(a_sector_range, split_valid_ff |-> (split_ff.sector <= SECTOR_5), "hue sector out of range")
   `ASSERT_HOLDS(a_clamped, split_valid_ff |-> (split_ff.sat <= ONE_Q15 && split_ff.val <= ONE_Q15), "saturation or value not clamped")

endmodule

`default_nettype wire

/* sv/hsv2rgb_pqt.sv */
`default_nettype none

// One stage: scale the value by the three factors to get p, q and t.
module hsv2rgb_pqt (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  hsv2rgb_pkg::factor_type      in_data,
   output logic                         out_valid,
   input  wire                          out_ready,
   output hsv2rgb_pkg::pqt_type         out_data
);
   import hsv2rgb_pkg::*;

   logic        pqt_valid_ff;
   pqt_type     pqt_ff;
   pqt_type     pqt_in;
   logic [31:0] prod_p;
   logic [31:0] prod_q;
   logic [31:0] prod_t;

   always_comb begin
      prod_p = 32'(in_data.val) * 32'(in_data.one_minus_s);
      prod_q = 32'(in_data.val) * 32'(in_data.one_minus_sf);
      prod_t = 32'(in_data.val) * 32'(in_data.one_minus_sg);
      pqt_in.sector = in_data.sector;
      pqt_in.val    = in_data.val;
      pqt_in.p      = prod_p[30:15];
      pqt_in.q      = prod_q[30:15];
      pqt_in.t      = prod_t[30:15];
   end

   assign in_ready = !pqt_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pqt_valid_ff <= 1'b0;
      end else if (in_ready) begin
         pqt_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         pqt_ff <= pqt_in;
      end
   end

   assign out_valid = pqt_valid_ff;
   assign out_data  = pqt_ff;

`include "assert_macros.svh"

   `ASSERT_NEVER(a_pqt_range, pqt_valid_ff && (pqt_ff.p > ONE_Q15 || pqt_ff.q > ONE_Q15 || pqt_ff.t > ONE_Q15), "channel term above one")

endmodule

`default_nettype wire

/* sv/hsv2rgb_pack.sv */
`default_nettype none

// Output stage: pick the channels for the sector, scale to 5/6/5 bits and pack.
module hsv2rgb_pack (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  hsv2rgb_pkg::pqt_type         in_data,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [15:0]                  out_word
);
   import hsv2rgb_pkg::*;

   logic        word_valid_ff;
   logic [15:0] word_ff;
   logic [15:0] word_in;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;

   always_comb begin
      unique case (in_data.sector)
         SECTOR_0: begin
            red = in_data.val; green = in_data.t;   blue = in_data.p;
         end
         SECTOR_1: begin
            red = in_data.q;   green = in_data.val; blue = in_data.p;
         end
         SECTOR_2: begin
            red = in_data.p;   green = in_data.val; blue = in_data.t;
         end
         SECTOR_3: begin
            red = in_data.p;   green = in_data.q;   blue = in_data.val;
         end
         SECTOR_4: begin
            red = in_data.t;   green = in_data.p;   blue = in_data.val;
         end
         default: begin
            red = in_data.val; green = in_data.p;   blue = in_data.q;
         end
      endcase
      word_in = {chan5(red), chan6(green), chan5(blue)};
   end

   assign in_ready = !word_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else if (in_ready) begin
         word_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = word_valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire
